// ----- design/lrsd_pkg.sv -----
// Package with the shared types and constants of the LZW/RLE90 stream decompressor.
package lrsd_pkg;

	localparam logic [1:0] REG_WIDTH_LIMIT = 2'd0;
	localparam logic [1:0] REG_RLE_ENABLE  = 2'd1;
	localparam logic [1:0] REG_EXP_LENGTH  = 2'd2;

	localparam logic [1:0] ST_BYTE = 2'd0;
	localparam logic [1:0] ST_MORE = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	localparam logic [8:0] CODE_CLEAR   = 9'h100;
	localparam logic [8:0] CODE_FIRST   = 9'h101;
	localparam logic [8:0] LIMIT_9BIT   = 9'h1ff;
	localparam logic [7:0] RLE_ESCAPE   = 8'h90;
	localparam logic [7:0] LITERAL_MAX  = 8'hff;
	localparam logic [4:0] START_WIDTH  = 5'd9;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_FEED,
		CMD_DROP,
		CMD_START,
		CMD_LOOP,
		CMD_SINK,
		CMD_EXT,
		CMD_TAKE,
		CMD_WALK,
		CMD_WPUSH
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic fin;
		logic pop;
		logic walk;
	} dp_status_t;

endpackage

// ----- design/lrsd_ctrl.sv -----
// Controller state machine that sequences the decompressor datapath.
module lrsd_ctrl
	import lrsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       req_type,
	output logic       in_ready,
	input  dp_status_t st,
	output cmd_t       cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FDROP = 10'b0000000010,
		S_WAIT  = 10'b0000000100,
		S_LOOP  = 10'b0000001000,
		S_SINK  = 10'b0000010000,
		S_RDROP = 10'b0000100000,
		S_EXT   = 10'b0001000000,
		S_TAKE  = 10'b0010000000,
		S_WALK  = 10'b0100000000,
		S_WPUSH = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (req_type) begin
						state_d = S_WAIT;
					end else begin
						cmd = CMD_FEED;
						state_d = S_FDROP;
					end
				end
			end
			S_FDROP: begin
				cmd = CMD_DROP;
				state_d = S_IDLE;
			end
			S_WAIT: begin
				if (!st.out_busy) begin
					cmd = CMD_START;
					state_d = st.fin ? S_IDLE : S_LOOP;
				end
			end
			S_LOOP: begin
				cmd = CMD_LOOP;
				if (st.fin) state_d = S_IDLE;
				else if (st.pop) state_d = S_SINK;
				else state_d = S_RDROP;
			end
			S_SINK: begin
				cmd = CMD_SINK;
				state_d = st.fin ? S_IDLE : S_LOOP;
			end
			S_RDROP: begin
				cmd = CMD_DROP;
				state_d = S_EXT;
			end
			S_EXT: begin
				cmd = CMD_EXT;
				state_d = st.fin ? S_IDLE : S_TAKE;
			end
			S_TAKE: begin
				cmd = CMD_TAKE;
				if (st.fin) state_d = S_IDLE;
				else if (st.walk) state_d = S_WALK;
				else state_d = S_LOOP;
			end
			S_WALK: begin
				cmd = CMD_WALK;
				if (st.fin) state_d = S_IDLE;
				else if (st.walk) state_d = S_WPUSH;
				else state_d = S_LOOP;
			end
			S_WPUSH: begin
				cmd = CMD_WPUSH;
				state_d = st.fin ? S_IDLE : S_WALK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/lrsd_datapath.sv -----
// Datapath of the decompressor: bit reader, code tables, expansion stack and RLE90 stage.
module lrsd_datapath
	import lrsd_pkg::*;
#(
	parameter int MAX_CODE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output dp_status_t  st,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic [7:0]  in_byte,
	input  logic        in_final,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        is_final,
	output logic [31:0] emitted_count
);

	localparam int AW = MAX_CODE_BITS;
	localparam int CW = MAX_CODE_BITS + 1;
	localparam int DEPTH = 1 << AW;

	logic [7:0]    pre_unused;
	logic [AW-1:0] pre_mem [DEPTH];
	logic [7:0]    suf_mem [DEPTH];
	logic [7:0]    stk_mem [DEPTH];
	logic [AW-1:0] pre_rd_q;
	logic [7:0]    suf_rd_q, stk_rd_q;

	logic [4:0]    lim_q;
	logic          rle_en_q;
	logic [31:0]   exp_q;

	logic [4:0]    cw_q;
	logic [CW-1:0] wlc_q, nfc_q, sp_q;
	logic [2:0]    grp_q;
	logic [AW-1:0] prev_code_q, code_q, cur_q;
	logic          prev_valid_q, need_lit_q;
	logic [7:0]    prev_first_q;
	logic [31:0]   bb_q;
	logic [5:0]    nbits_q;
	logic [6:0]    skip_q;
	logic          ended_q, esc_q, err_q;
	logic [7:0]    rle_last_q, rpt_q;
	logic [31:0]   pos_q;

	logic [CW-1:0] cap;
	logic          lim_bad, pos_done, sp_full, need_bump, has_code;
	logic [6:0]    pad;
	logic [5:0]    drop_n;
	logic [31:0]   code_mask;
	logic [7:0]    sv, rep, emit_val;
	logic          emit_req, sink_err, lit_path, is_clear, is_kwkwk;
	logic          res_we, res_err, res_emit;
	logic [1:0]    res_st;
	logic          stk_we, stk_re, tbl_we, tbl_re;
	logic [AW-1:0] stk_wa, stk_ra;
	logic [7:0]    stk_wd;
	logic [4:0]    cw_next;

	assign pre_unused = 8'(LITERAL_MAX);
	assign cap = CW'(1) << lim_q;
	assign lim_bad = (lim_q < START_WIDTH) || (lim_q > 5'(MAX_CODE_BITS));
	assign pos_done = (pos_q >= exp_q);
	assign sp_full = (sp_q >= cap);
	assign need_bump = (wlc_q < nfc_q);
	assign pad = 7'(8'(3'(3'd0 - grp_q)) * 8'(cw_q));
	assign drop_n = (7'(nbits_q) < skip_q) ? nbits_q : 6'(skip_q);
	assign code_mask = (32'(1) << cw_q) - 32'd1;
	assign has_code = (nbits_q >= 6'(cw_q)) || (ended_q && (nbits_q != 6'd0));
	assign cw_next = cw_q + 5'd1;

	assign sv = stk_rd_q;
	assign rep = sv - 8'd1;
	assign lit_path = need_lit_q || (!prev_valid_q && (code_q != AW'(CODE_CLEAR)));
	assign is_clear = (code_q == AW'(CODE_CLEAR));
	assign is_kwkwk = (CW'(code_q) >= nfc_q);

	always_comb begin
		emit_req = 1'b0;
		emit_val = sv;
		sink_err = 1'b0;
		if (!rle_en_q) begin
			emit_req = 1'b1;
		end else if (!esc_q) begin
			emit_req = (sv != RLE_ESCAPE);
		end else if (sv == 8'd0) begin
			emit_req = 1'b1;
			emit_val = RLE_ESCAPE;
		end else begin
			sink_err = (rep != 8'd0) && (pos_done || ({24'd0, rep} > (exp_q - pos_q)));
		end
	end

	always_comb begin
		res_we = 1'b0;
		res_err = 1'b0;
		res_emit = 1'b0;
		res_st = ST_ERR;
		st.pop = 1'b0;
		st.walk = 1'b0;
		case (cmd)
			CMD_START: begin
				if (err_q || lim_bad) begin
					res_we = 1'b1;
				end else if (exp_q == 32'd0) begin
					res_we = 1'b1;
					res_st = ((nbits_q == 6'd0) && !ended_q) ? ST_DONE : ST_ERR;
				end
			end
			CMD_LOOP: begin
				if (rpt_q != 8'd0) begin
					res_we = 1'b1;
					res_emit = !pos_done;
					res_err = pos_done;
				end else if (sp_q != CW'(0)) begin
					st.pop = 1'b1;
				end else if (pos_done) begin
					res_we = 1'b1;
					res_st = esc_q ? ST_ERR : ST_DONE;
				end else if (need_bump && (cw_q >= lim_q)) begin
					res_we = 1'b1;
					res_err = 1'b1;
				end
			end
			CMD_SINK: begin
				if (emit_req) begin
					res_we = 1'b1;
					res_emit = !pos_done;
					res_err = pos_done;
				end else if (sink_err) begin
					res_we = 1'b1;
					res_err = 1'b1;
				end
			end
			CMD_EXT: begin
				if ((skip_q != 7'd0) || !has_code) begin
					res_we = 1'b1;
					res_st = ended_q ? ST_ERR : ST_MORE;
					res_err = ended_q;
				end
			end
			CMD_TAKE: begin
				if (lit_path) begin
					res_we = (code_q > AW'(LITERAL_MAX)) || sp_full;
				end else if (!is_clear) begin
					res_we = is_kwkwk && sp_full;
					st.walk = !res_we;
				end
				res_err = res_we;
			end
			CMD_WALK: begin
				if (cur_q > AW'(LITERAL_MAX)) begin
					res_we = (CW'(cur_q) >= cap);
					st.walk = !res_we;
				end else begin
					res_we = sp_full;
				end
				res_err = res_we;
			end
			CMD_WPUSH: begin
				res_we = sp_full;
				res_err = res_we;
			end
			default: begin
				res_we = 1'b0;
			end
		endcase
		if (res_emit) res_st = ST_BYTE;
		st.fin = res_we;
		st.out_busy = out_valid;
	end

	always_comb begin
		stk_we = 1'b0;
		stk_wa = sp_q[AW-1:0];
		stk_wd = code_q[7:0];
		stk_re = (cmd == CMD_LOOP) && st.pop;
		stk_ra = AW'(sp_q - CW'(1));
		tbl_we = 1'b0;
		tbl_re = (cmd == CMD_WALK) && st.walk;
		case (cmd)
			CMD_TAKE: begin
				if (!res_we && lit_path) begin
					stk_we = 1'b1;
				end else if (!res_we && st.walk && is_kwkwk) begin
					stk_we = 1'b1;
					stk_wd = prev_first_q;
				end
			end
			CMD_WALK: begin
				if (!res_we && !st.walk) begin
					stk_we = 1'b1;
					stk_wd = cur_q[7:0];
					tbl_we = (nfc_q < cap);
				end
			end
			CMD_WPUSH: begin
				stk_we = !res_we;
				stk_wd = suf_rd_q;
			end
			default: begin
				stk_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			pre_mem[nfc_q[AW-1:0]] <= prev_code_q;
			suf_mem[nfc_q[AW-1:0]] <= cur_q[7:0];
		end
		if (tbl_re) begin
			pre_rd_q <= pre_mem[cur_q];
			suf_rd_q <= suf_mem[cur_q];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			out_byte <= res_emit ? ((cmd == CMD_LOOP) ? rle_last_q : emit_val) : 8'd0;
			status <= res_st;
			is_final <= res_emit && ((pos_q + 32'd1) == exp_q);
			emitted_count <= res_emit ? (pos_q + 32'd1) : pos_q;
		end
		if (cmd == CMD_EXT) begin
			if (nbits_q >= 6'(cw_q)) begin
				code_q <= AW'(bb_q & code_mask);
			end else begin
				code_q <= AW'(bb_q);
			end
		end
		if (cmd == CMD_TAKE && is_kwkwk) begin
			cur_q <= prev_code_q;
		end else if (cmd == CMD_TAKE) begin
			cur_q <= code_q;
		end else if (cmd == CMD_WPUSH) begin
			cur_q <= pre_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			lim_q <= 5'd12;
			rle_en_q <= 1'b0;
			exp_q <= 32'd0;
			cw_q <= START_WIDTH;
			wlc_q <= CW'(LIMIT_9BIT);
			nfc_q <= CW'(CODE_FIRST);
			sp_q <= '0;
			grp_q <= 3'd0;
			prev_code_q <= '0;
			prev_valid_q <= 1'b0;
			need_lit_q <= 1'b0;
			prev_first_q <= 8'd0;
			bb_q <= 32'd0;
			nbits_q <= 6'd0;
			skip_q <= 7'd0;
			ended_q <= 1'b0;
			esc_q <= 1'b0;
			err_q <= 1'b0;
			rle_last_q <= 8'd0;
			rpt_q <= 8'd0;
			pos_q <= 32'd0;
		end else begin
			if (res_we) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (res_err) err_q <= 1'b1;
			if (res_emit) pos_q <= pos_q + 32'd1;
			if (stk_we) sp_q <= sp_q + CW'(1);
			if (cfg_we) begin
				case (cfg_addr)
					REG_WIDTH_LIMIT: lim_q <= cfg_wdata[4:0];
					REG_RLE_ENABLE:  rle_en_q <= cfg_wdata[0];
					REG_EXP_LENGTH:  exp_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (cmd)
				CMD_FEED: begin
					if (!ended_q && !err_q) begin
						if (nbits_q > 6'd24) begin
							err_q <= 1'b1;
						end else begin
							bb_q <= bb_q | ({24'd0, in_byte} << nbits_q);
							nbits_q <= nbits_q + 6'd8;
							if (in_final) ended_q <= 1'b1;
						end
					end
				end
				CMD_DROP: begin
					bb_q <= bb_q >> drop_n;
					nbits_q <= nbits_q - drop_n;
					skip_q <= skip_q - 7'(drop_n);
				end
				CMD_LOOP: begin
					if (rpt_q != 8'd0) begin
						if (!pos_done) rpt_q <= rpt_q - 8'd1;
					end else if (st.pop) begin
						sp_q <= sp_q - CW'(1);
					end else if (!pos_done && need_bump) begin
						skip_q <= skip_q + pad;
						grp_q <= 3'd0;
						if (cw_q < lim_q) begin
							cw_q <= cw_next;
							wlc_q <= (cw_next == lim_q) ? cap
								: ((CW'(1) << cw_next) - CW'(1));
						end
					end
				end
				CMD_SINK: begin
					if (rle_en_q) begin
						if (!esc_q) begin
							if (sv == RLE_ESCAPE) esc_q <= 1'b1;
							else rle_last_q <= sv;
						end else begin
							esc_q <= 1'b0;
							if (sv != 8'd0 && !sink_err) rpt_q <= rep;
						end
					end
				end
				CMD_EXT: begin
					if (skip_q == 7'd0 && has_code) begin
						grp_q <= grp_q + 3'd1;
						if (nbits_q >= 6'(cw_q)) begin
							bb_q <= bb_q >> cw_q;
							nbits_q <= nbits_q - 6'(cw_q);
						end else begin
							bb_q <= 32'd0;
							nbits_q <= 6'd0;
						end
					end
				end
				CMD_TAKE: begin
					if (!res_we && lit_path) begin
						prev_code_q <= code_q;
						prev_first_q <= code_q[7:0];
						prev_valid_q <= 1'b1;
						need_lit_q <= 1'b0;
					end else if (!res_we && is_clear) begin
						skip_q <= skip_q + pad;
						grp_q <= 3'd0;
						cw_q <= START_WIDTH;
						wlc_q <= CW'(LIMIT_9BIT);
						nfc_q <= CW'(CODE_FIRST);
						need_lit_q <= 1'b1;
					end
				end
				CMD_WALK: begin
					if (!res_we && !st.walk) begin
						if (tbl_we) nfc_q <= nfc_q + CW'(1);
						prev_code_q <= code_q;
						prev_first_q <= cur_q[7:0] & pre_unused;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- design/lzw_rle90_stream_decompressor_unit.sv -----
// Top level of the LZW stream decompressor with variable code width and RLE90 stage.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | req_type, in_byte, in_final
//  out     | output    | out_valid / out_ready| out_byte, status, is_final, emitted_count
//  cfg     | input     | cfg_we               | cfg_addr, cfg_wdata
//
// A fed byte passes the feed and drop states. A drain starts once the output is free, pops each
// stack byte via the loop and sink states, repeats an RLE90 byte in the loop state and reads
// each code via the loop, drop, extract and take states; a non-literal code walks its prefix
// links via the walk and push states. Stack and table memories have registered read ports.
// Reset is asynchronous and clears all control state; the tables need no clearing.
// One item is processed at a time; a drain waits while an earlier result is not taken.
module lzw_rle90_stream_decompressor_unit
	import lrsd_pkg::*;
#(
	parameter int MAX_CODE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  in_byte,
	input  logic        in_final,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        is_final,
	output logic [31:0] emitted_count,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	cmd_t       cmd;
	dp_status_t st;

	lrsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lrsd_datapath #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_byte       (in_byte),
		.in_final      (in_final),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.status        (status),
		.is_final      (is_final),
		.emitted_count (emitted_count)
	);

endmodule

// ----- design/lrsd_checker.sv -----
// Port-level checker for the decompressor and its bind to the top level.
module lrsd_checker
	import lrsd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [1:0]  status,
	input logic        is_final,
	input logic [31:0] emitted_count
);

	// A result that carries no byte shows a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_BYTE) |-> out_byte == 8'd0)
		else $error("status without byte shows nonzero byte");

	a_final_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_final |-> status == ST_BYTE && emitted_count != 32'd0)
		else $error("final flag on a result without a byte");

	// A new result only appears after the input side stopped taking items.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the block was idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(emitted_count) && $stable(status))
		else $error("stalled result changed");

endmodule

bind lzw_rle90_stream_decompressor_unit lrsd_checker u_lrsd_checker (.*);

// ----- verif/tb_lzw_rle90_stream_decompressor_unit.sv -----
// Self-checking testbench of the LZW/RLE90 stream decompressor: directed table, then random streams.
module tb_lzw_rle90_stream_decompressor_unit;
	import lrsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int ITEM_GOAL = 1850;

	typedef enum logic [1:0] {OP_CFG, OP_FEED, OP_DRAIN} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [1:0]  addr;
		logic [31:0] data;
		logic [7:0]  byt;
		bit          chk;
		logic [1:0]  st;
		logic [31:0] cnt;
	} dir_row_t;

	typedef struct {
		logic [7:0]  byt;
		logic [1:0]  st;
		logic        fin;
		logic [31:0] cnt;
	} dec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        in_final = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic        is_final;
	logic [31:0] emitted_count;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = 2'd0;
	logic [31:0] cfg_wdata = 32'd0;

	lzw_rle90_stream_decompressor_unit i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	dec_result_t decoded_q[$];
	int          n_fail = 0;
	int          n_items = 0;
	int          n_results = 0;
	int          n_streams = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	logic [1:0]  last_st = ST_MORE;

	// Shadow copy of the decoder state.
	logic [15:0] dec_prefix[65536];
	logic [7:0]  dec_suffix[65536];
	logic [7:0]  dec_stack[65536];
	logic [31:0] dec_bits;
	int unsigned dec_sp, dec_nbits, dec_skip, dec_cw, dec_wlim, dec_next, dec_grp;
	int unsigned dec_prev, dec_first, dec_rlast, dec_rrep, dec_pos;
	bit          dec_ended, dec_pvalid, dec_esc, dec_err, dec_needlit;
	int unsigned cfg_lim = 12, cfg_rle = 0, cfg_len = 0;

	// Stream builder state.
	int unsigned gen_w, gen_wlim, gen_next, gen_grp, gen_prev, gen_cap, gen_total;
	bit          gen_needlit;
	int unsigned gen_len[65536];
	logic [7:0]  gen_acc;
	int          gen_nacc, gen_skip;
	logic [7:0]  stream_q[$];

	function automatic void dec_drop_skip();
		int unsigned n;
		n = (dec_skip < dec_nbits) ? dec_skip : dec_nbits;
		dec_bits = (n >= 32) ? 32'd0 : (dec_bits >> n);
		dec_nbits -= n;
		dec_skip -= n;
	endfunction

	function automatic void dec_start_pad();
		dec_skip += ((8 - dec_grp) & 7) * dec_cw;
		dec_grp = 0;
	endfunction

	function automatic int dec_read_code(int unsigned lim, int unsigned cap,
		output int unsigned code);
		code = 0;
		if (dec_wlim < dec_next) begin
			dec_start_pad();
			if (dec_cw >= lim) return 2;
			dec_cw++;
			dec_wlim = (dec_cw == lim) ? cap : ((32'd1 << dec_cw) - 1);
		end
		dec_drop_skip();
		if (dec_skip != 0) return dec_ended ? 2 : 1;
		if (dec_nbits >= dec_cw) begin
			code = dec_bits & ((32'd1 << dec_cw) - 1);
			dec_bits = dec_bits >> dec_cw;
			dec_nbits -= dec_cw;
		end else if (dec_ended && dec_nbits != 0) begin
			code = dec_bits;
			dec_bits = 32'd0;
			dec_nbits = 0;
		end else begin
			return dec_ended ? 2 : 1;
		end
		dec_grp = (dec_grp + 1) & 7;
		return 0;
	endfunction

	function automatic bit dec_push(int unsigned cap, int unsigned v);
		if (dec_sp >= cap) return 1'b0;
		dec_stack[dec_sp & 16'hffff] = v[7:0];
		dec_sp++;
		return 1'b1;
	endfunction

	function automatic bit dec_take(int unsigned code, int unsigned cap);
		int unsigned cur;
		if (dec_needlit || (!dec_pvalid && code != CODE_CLEAR)) begin
			if (code > LITERAL_MAX || !dec_push(cap, code)) return 1'b0;
			dec_prev = code;
			dec_first = code;
			dec_pvalid = 1'b1;
			dec_needlit = 1'b0;
			return 1'b1;
		end
		if (code == CODE_CLEAR) begin
			dec_start_pad();
			dec_cw = START_WIDTH;
			dec_wlim = LIMIT_9BIT;
			dec_next = CODE_FIRST;
			dec_needlit = 1'b1;
			return 1'b1;
		end
		cur = code;
		if (code >= dec_next) begin
			if (!dec_push(cap, dec_first)) return 1'b0;
			cur = dec_prev;
		end
		while (cur > LITERAL_MAX) begin
			if (cur >= cap || !dec_push(cap, dec_suffix[cur & 16'hffff])) return 1'b0;
			cur = dec_prefix[cur & 16'hffff];
		end
		if (!dec_push(cap, cur)) return 1'b0;
		if (dec_next < cap) begin
			dec_prefix[dec_next & 16'hffff] = dec_prev[15:0];
			dec_suffix[dec_next & 16'hffff] = cur[7:0];
			dec_next++;
		end
		dec_prev = code;
		dec_first = cur;
		return 1'b1;
	endfunction

	function automatic int dec_emit(int unsigned v, output logic [7:0] b);
		b = 8'h00;
		if (dec_pos >= cfg_len) return 2;
		dec_pos++;
		b = v[7:0];
		return 0;
	endfunction

	function automatic int dec_sink(int unsigned v, output logic [7:0] b);
		int unsigned rep;
		b = 8'h00;
		if (cfg_rle == 0) return dec_emit(v, b);
		if (!dec_esc) begin
			if (v == RLE_ESCAPE) begin
				dec_esc = 1'b1;
				return 1;
			end
			dec_rlast = v;
			return dec_emit(v, b);
		end
		dec_esc = 1'b0;
		if (v == 0) return dec_emit(RLE_ESCAPE, b);
		rep = v - 1;
		if (dec_pos >= cfg_len || rep > cfg_len - dec_pos) begin
			if (rep != 0) return 2;
		end
		dec_rrep = rep;
		return 1;
	endfunction

	function automatic dec_result_t dec_drain();
		dec_result_t res;
		logic [7:0]  b;
		int unsigned cap, code;
		int          r;
		b = 8'h00;
		if (dec_err || cfg_lim < 9 || cfg_lim > 16) begin
			res.st = ST_ERR;
		end else if (cfg_len == 0) begin
			res.st = (dec_nbits == 0 && !dec_ended) ? ST_DONE : ST_ERR;
		end else begin
			cap = 32'd1 << cfg_lim;
			while (1) begin
				if (dec_rrep != 0) begin
					r = dec_emit(dec_rlast, b);
					if (r == 0) begin
						dec_rrep--;
						res.st = ST_BYTE;
					end else begin
						dec_err = 1'b1;
						res.st = ST_ERR;
					end
					break;
				end
				if (dec_sp != 0) begin
					dec_sp--;
					r = dec_sink(dec_stack[dec_sp & 16'hffff], b);
					if (r == 0) begin
						res.st = ST_BYTE;
						break;
					end
					if (r == 2) begin
						dec_err = 1'b1;
						res.st = ST_ERR;
						break;
					end
					continue;
				end
				if (dec_pos >= cfg_len) begin
					res.st = dec_esc ? ST_ERR : ST_DONE;
					break;
				end
				r = dec_read_code(cfg_lim, cap, code);
				if (r == 1) begin
					res.st = ST_MORE;
					break;
				end
				if (r == 2 || !dec_take(code, cap)) begin
					dec_err = 1'b1;
					res.st = ST_ERR;
					break;
				end
			end
		end
		res.byt = (res.st == ST_BYTE) ? b : 8'h00;
		res.fin = (res.st == ST_BYTE && dec_pos == cfg_len);
		res.cnt = dec_pos;
		return res;
	endfunction

	function automatic void dec_feed(logic [7:0] b, logic fin);
		if (dec_ended || dec_err) return;
		if (dec_nbits > 24) begin
			dec_err = 1'b1;
			return;
		end
		dec_bits |= 32'(b) << dec_nbits;
		dec_nbits += 8;
		if (fin) dec_ended = 1'b1;
		dec_drop_skip();
	endfunction

	function automatic void gen_put(int unsigned v, int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			gen_acc[gen_nacc] = v[i];
			gen_nacc++;
			if (gen_nacc == 8) begin
				if (gen_skip > 0) gen_skip--;
				else stream_q.push_back(gen_acc);
				gen_acc = 8'h00;
				gen_nacc = 0;
			end
		end
	endfunction

	function automatic int unsigned gen_entry_len(int unsigned c);
		return (c <= LITERAL_MAX) ? 1 : gen_len[c];
	endfunction

	function automatic void gen_code(int unsigned code);
		int unsigned l;
		if (gen_wlim < gen_next) begin
			gen_put(0, ((8 - gen_grp) & 7) * gen_w);
			gen_grp = 0;
			gen_w++;
			gen_wlim = (gen_w == cfg_lim) ? gen_cap : ((32'd1 << gen_w) - 1);
		end
		gen_put(code, gen_w);
		gen_grp = (gen_grp + 1) & 7;
		if (gen_needlit) begin
			gen_total += 1;
			gen_prev = code;
			gen_needlit = 1'b0;
		end else if (code == CODE_CLEAR) begin
			gen_put(0, ((8 - gen_grp) & 7) * gen_w);
			gen_grp = 0;
			gen_w = START_WIDTH;
			gen_wlim = LIMIT_9BIT;
			gen_next = CODE_FIRST;
			gen_needlit = 1'b1;
		end else begin
			l = (code >= gen_next) ? gen_entry_len(gen_prev) + 1 : gen_entry_len(code);
			gen_total += l;
			if (gen_next < gen_cap) begin
				gen_len[gen_next] = gen_entry_len(gen_prev) + 1;
				gen_next++;
			end
			gen_prev = code;
		end
	endfunction

	function automatic int unsigned gen_literal();
		case ($urandom % 8)
			0: return RLE_ESCAPE;
			1: return $urandom % 4;
			2: return LITERAL_MAX;
			default: return $urandom % 256;
		endcase
	endfunction

	// Builds one segment of the stream; all but the last end with a clear code.
	function automatic void gen_segment(bit last, int unsigned n_codes);
		int unsigned hi;
		gen_cap = 32'd1 << cfg_lim;
		gen_total = 0;
		for (int unsigned i = 0; i < n_codes; i++) begin
			if (gen_needlit || $urandom % 2) begin
				gen_code(gen_literal());
			end else begin
				hi = (gen_next < gen_cap) ? gen_next : gen_cap - 1;
				gen_code($urandom_range(CODE_FIRST, hi));
			end
		end
		if (!last) gen_code(CODE_CLEAR);
		else if (gen_nacc > 0) gen_put(0, 8 - gen_nacc);
	endfunction

	task automatic issue(bit drain, logic [7:0] byt, logic fin, bit chk = 1'b0,
		logic [1:0] xst = ST_BYTE, logic [31:0] xcnt = 32'd0);
		dec_result_t res;
		if (drain) begin
			res = dec_drain();
			if (chk) begin
				res.st = xst;
				res.cnt = xcnt;
				res.byt = 8'h00;
				res.fin = 1'b0;
			end
			decoded_q.push_back(res);
			last_st = res.st;
		end else begin
			dec_feed(byt, fin);
			last_st = ST_BYTE;
		end
		if (burst_left == 0) begin
			if ($urandom % 4 != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			burst_left = ($urandom % 8 == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= drain;
		in_byte <= byt;
		in_final <= fin;
		do @(posedge clk); while (!in_ready);
		n_items++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] addr, logic [31:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_WIDTH_LIMIT: cfg_lim = data & 32'h1f;
			REG_RLE_ENABLE:  cfg_rle = data & 32'h1;
			REG_EXP_LENGTH:  cfg_len = data;
			default: ;
		endcase
	endtask

	// Feeds the queued bytes and drains until the decoder starves, finishes or reports an error.
	task automatic run_segment(bit last);
		int idx;
		idx = 0;
		while (last_st != ST_ERR) begin
			if (idx < stream_q.size() && dec_nbits <= 24 && (last_st == ST_MORE
				|| last_st == ST_DONE || (dec_nbits <= 16 && $urandom % 3 == 0))) begin
				issue(1'b0, stream_q[idx], last && idx == stream_q.size() - 1);
				idx++;
			end else if (idx == stream_q.size() && (last ? last_st == ST_DONE
				: last_st == ST_MORE)) begin
				break;
			end else begin
				issue(1'b1, 8'($urandom), 1'($urandom));
			end
		end
		stream_q.delete();
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			n_results++;
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				n_fail++;
			end else begin
				dec_result_t x;
				x = decoded_q.pop_front();
				if (out_byte !== x.byt) begin
					$error("out_byte: expected %0h, got %0h", x.byt, out_byte);
					n_fail++;
				end
				if (status !== x.st) begin
					$error("status: expected %0d, got %0d", x.st, status);
					n_fail++;
				end
				if (is_final !== x.fin) begin
					$error("is_final: expected %0d, got %0d", x.fin, is_final);
					n_fail++;
				end
				if (emitted_count !== x.cnt) begin
					$error("emitted_count: expected %0d, got %0d", x.cnt, emitted_count);
					n_fail++;
				end
			end
		end
	end

	int stall_cyc = 0;
	int stall_mode = 0;
	always @(posedge clk) begin
		stall_cyc++;
		if (stall_cyc % 300 == 0) stall_mode = $urandom % 4;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom);
			2: out_ready <= (stall_cyc % 7) < 4;
			default: out_ready <= ($urandom % 6 == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL lzw_rle90_stream_decompressor_unit");
			$finish;
		end
	end

	dir_row_t dir_tab[15];

	initial begin
		int unsigned lims[6];
		dir_tab = '{
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_DONE, 32'd0},
			'{OP_CFG, REG_WIDTH_LIMIT, 32'd8, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'hff, 1'b1, ST_ERR, 32'd0},
			'{OP_CFG, REG_WIDTH_LIMIT, 32'd17, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_ERR, 32'd0},
			'{OP_CFG, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_ERR, 32'd0},
			'{OP_CFG, REG_WIDTH_LIMIT, 32'd16, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_DONE, 32'd0},
			'{OP_FEED, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_ERR, 32'd0},
			'{OP_CFG, REG_RLE_ENABLE, 32'd1, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_CFG, REG_EXP_LENGTH, 32'hffffffff, 8'h00, 1'b0, ST_BYTE, 32'd0},
			'{OP_DRAIN, REG_WIDTH_LIMIT, 32'd0, 8'h00, 1'b1, ST_MORE, 32'd0},
			'{OP_CFG, REG_WIDTH_LIMIT, 32'd9, 8'h00, 1'b0, ST_BYTE, 32'd0}
		};
		lims = '{9, 10, 11, 12, 13, 16};
		dec_bits = 32'd0;
		{dec_sp, dec_nbits, dec_skip, dec_grp, dec_prev, dec_first} = '0;
		{dec_rlast, dec_rrep, dec_pos} = '0;
		{dec_ended, dec_pvalid, dec_esc, dec_err, dec_needlit} = '0;
		dec_cw = START_WIDTH;
		dec_wlim = LIMIT_9BIT;
		dec_next = CODE_FIRST;
		gen_w = START_WIDTH;
		gen_wlim = LIMIT_9BIT;
		gen_next = CODE_FIRST;
		gen_grp = 0;
		gen_needlit = 1'b1;
		gen_acc = 8'h00;
		gen_nacc = 0;
		gen_skip = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			case (dir_tab[i].op)
				OP_CFG:  cfg_write(dir_tab[i].addr, dir_tab[i].data);
				OP_FEED: issue(1'b0, dir_tab[i].byt, 1'b0);
				default: issue(1'b1, dir_tab[i].byt, 1'b1, dir_tab[i].chk,
					dir_tab[i].st, dir_tab[i].cnt);
			endcase
		end

		// The stream opens with literal zero, whose low byte was already fed above.
		gen_skip = 1;
		gen_cap = 32'd1 << cfg_lim;
		gen_code(0);
		gen_segment(1'b0, $urandom_range(20, 200));
		run_segment(1'b0);
		n_streams++;
		while (n_items < ITEM_GOAL - 450 && last_st != ST_ERR) begin
			cfg_write(REG_WIDTH_LIMIT, ($urandom % 3 == 0) ? $urandom_range(9, 16)
				: lims[$urandom % 6]);
			cfg_write(REG_RLE_ENABLE, $urandom % 2);
			gen_segment(1'b0, (cfg_lim == 9) ? $urandom_range(5, 200)
				: (($urandom % 4 == 0) ? $urandom_range(260, 340) : $urandom_range(5, 120)));
			run_segment(1'b0);
			n_streams++;
		end

		if ($urandom % 2) begin
			cfg_write(REG_RLE_ENABLE, 0);
			gen_segment(1'b1, $urandom_range(5, 40));
			cfg_write(REG_EXP_LENGTH, dec_pos + gen_total);
			run_segment(1'b1);
		end else begin
			// Overfilling the bit buffer is an error that stays until reset.
			repeat (5) issue(1'b0, 8'($urandom), 1'b0);
			repeat (3) issue(1'b1, 8'($urandom), 1'($urandom));
		end
		repeat (2) issue(1'b1, 8'($urandom), 1'($urandom));
		repeat (2) issue(1'b0, 8'($urandom), 1'($urandom));
		issue(1'b1, 8'($urandom), 1'b0);

		settle();
		repeat (40) @(posedge clk);
		$display("Run covered %0d transfers in, %0d results, %0d stream segments.",
			n_items, n_results, n_streams);
		$display("Decoded %0d bytes; final status %0d.", dec_pos, last_st);
		if (n_fail == 0 && decoded_q.size() == 0) begin
			$display("PASS lzw_rle90_stream_decompressor_unit");
		end else begin
			$display("FAIL lzw_rle90_stream_decompressor_unit");
		end
		$finish;
	end

endmodule
